/* rtl/core/md5_stream_hasher_core_defines.svh */
// assertion macros used by the checker file
`ifndef MD5_STREAM_HASHER_CORE_DEFINES_SVH
`define MD5_STREAM_HASHER_CORE_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define MD5_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked while out of reset
`define MD5_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/md5_pkg.sv */
package md5_pkg;

   // chaining value after reset and after each digest
   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hEFCDAB89;
   localparam logic [31:0] IV_C = 32'h98BADCFE;
   localparam logic [31:0] IV_D = 32'h10325476;

   // block geometry
   localparam logic [5:0] POS_LAST   = 6'd63;
   localparam logic [5:0] POS_LENGTH = 6'd56;
   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam logic [5:0] ROUND_LAST = 6'd63;
   localparam logic [1:0] WORD_LAST  = 2'd3;

   typedef logic [3:0][31:0] chain_type;

   // control from the sequencer to the round unit
   typedef struct packed {
      logic load;
      logic step;
      logic add;
      logic rearm;
   } round_cmd_type;

   // byte write into the block buffer
   typedef struct packed {
      logic       we;
      logic [3:0] addr;
      logic [1:0] lane;
      logic [7:0] data;
   } buf_wr_type;

   // additive constant of each round
   function automatic logic [31:0] round_const(input logic [5:0] r);
      logic [31:0] k;
      unique case (r)
         6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   // rotate amount, by quarter and round within the group of four
   function automatic logic [4:0] rot_amount(input logic [5:0] r);
      logic [4:0] s;
      unique case ({r[5:4], r[1:0]})
         4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
         4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
         4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
         4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
         default: s = 5'd0;
      endcase
      return s;
   endfunction

   // message word used by each round
   function automatic logic [3:0] msg_index(input logic [5:0] r);
      logic [3:0] g;
      unique case (r[5:4])
         2'd0: g = r[3:0];
         2'd1: g = 4'(r[3:0] * 4'd5) + 4'd1;
         2'd2: g = 4'(r[3:0] * 4'd3) + 4'd5;
         2'd3: g = 4'(r[3:0] * 4'd7);
         default: g = r[3:0];
      endcase
      return g;
   endfunction

   function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
      logic [63:0] t;
      t = {x, x} << s;
      return t[63:32];
   endfunction

endpackage

/* rtl/core/md5_if.sv */
// input channel: one message byte per item
interface md5_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       last_byte;

   modport source (output valid, data_byte, has_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, has_byte, last_byte, output ready);
endinterface

// result channel: one digest word per item
interface md5_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [1:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

/* rtl/core/md5_msg_buf.sv */
module md5_msg_buf
   import md5_pkg::*;
(
   input  logic        clock,
   input  buf_wr_type  wr,
   input  logic [3:0]  rd_addr,
   output logic [31:0] rd_data
);

   logic [15:0][31:0] words_ff;

   // byte lane write; every lane of a word is written before the block is hashed
   always_ff @(posedge clock) begin
      if (wr.we) begin
         words_ff[wr.addr][{wr.lane, 3'b000} +: 8] <= wr.data;
      end
   end

   assign rd_data = words_ff[rd_addr];

endmodule

/* rtl/core/md5_round_unit.sv */
module md5_round_unit
   import md5_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  round_cmd_type cmd,
   input  logic [5:0]    round,
   input  logic [31:0]   msg_word,
   output chain_type     chain
);

   chain_type   chain_ff, chain_in;
   chain_type   regs_ff, regs_in;
   logic [31:0] a, b, c, d, f, sum, b_new;

   assign a = regs_ff[0];
   assign b = regs_ff[1];
   assign c = regs_ff[2];
   assign d = regs_ff[3];

   // round function by quarter
   always_comb begin
      unique case (round[5:4])
         2'd0: f = d ^ (b & (c ^ d));
         2'd1: f = c ^ (d & (b ^ c));
         2'd2: f = b ^ c ^ d;
         2'd3: f = c ^ (b | ~d);
         default: f = '0;
      endcase
   end

   // one round of the shared datapath
   assign sum   = a + f + round_const(round) + msg_word;
   assign b_new = b + rotl32(sum, rot_amount(round));

   // next working and chaining values
   always_comb begin
      chain_in = chain_ff;
      regs_in  = regs_ff;
      priority if (cmd.rearm) begin
         chain_in = {IV_D, IV_C, IV_B, IV_A};
      end else if (cmd.load) begin
         regs_in = chain_ff;
      end else if (cmd.step) begin
         regs_in[0] = d;
         regs_in[1] = b_new;
         regs_in[2] = b;
         regs_in[3] = c;
      end else if (cmd.add) begin
         for (int i = 0; i < 4; i++) begin
            chain_in[i] = chain_ff[i] + regs_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= {IV_D, IV_C, IV_B, IV_A};
         regs_ff  <= '0;
      end else begin
         chain_ff <= chain_in;
         regs_ff  <= regs_in;
      end
   end

   assign chain = chain_ff;

endmodule

/* rtl/core/md5_stream_hasher_core.sv */
// md5 digest of a byte stream, one message byte per req item.
// req carries data_byte, has_byte and last_byte; an item with has_byte low and
// last_byte low changes nothing. last_byte ends the message, with or without a
// byte on the same item, so an empty message is hashed by one such item.
// rsp then gives four items: digest words 0..3 (bytes little-endian), the
// fourth flagged by last_word.
// timing: a byte is taken each cycle while the block buffer fills; the 64th
// byte of a block starts a hash (1 load, 64 rounds on the single shared round
// unit, 1 chaining add). After last_byte the 9 to 72 pad bytes are written
// one per cycle, with a hash after each filled block, one or two blocks, then
// the four words go out, one per cycle when rsp is ready.
// req.ready is high only while the block waits for a byte; it is low during
// hashing, padding and while digest words are being sent. A stalled rsp
// holds its word until taken, and the block takes no byte meanwhile.
// reset (synchronous, active high) loads the md5 initial chaining value,
// clears the byte count and leaves the block waiting for the first byte.
module md5_stream_hasher_core
   import md5_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   md5_req_if.sink    req,
   md5_rsp_if.source  rsp
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_ADD,
      ST_OUT
   } state_type;

   state_type     state_ff, state_in;
   state_type     ret_ff, ret_in;
   logic [5:0]    pos_ff, pos_in;
   logic [63:0]   count_ff, count_in;
   logic [5:0]    round_ff, round_in;
   logic          pad_first_ff, pad_first_in;
   logic          len_phase_ff, len_phase_in;
   logic [1:0]    word_ff, word_in;

   buf_wr_type    wr;
   round_cmd_type cmd;
   logic [31:0]   msg_word;
   chain_type     chain;
   logic [63:0]   bit_len;
   logic [5:0]    pos_next;

   md5_msg_buf u_msg_buf (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (msg_index(round_ff)),
      .rd_data (msg_word)
   );

   md5_round_unit u_round_unit (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .round    (round_ff),
      .msg_word (msg_word),
      .chain    (chain)
   );

   assign bit_len  = {count_ff[60:0], 3'b000};
   assign pos_next = pos_ff + 6'd1;

   // handshake and result fields
   assign req.ready       = (state_ff == ST_IDLE);
   assign rsp.valid       = (state_ff == ST_OUT);
   assign rsp.digest_word = chain[word_ff];
   assign rsp.word_index  = word_ff;
   assign rsp.last_word   = (word_ff == WORD_LAST);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      round_in     = round_ff;
      pad_first_in = pad_first_ff;
      len_phase_in = len_phase_ff;
      word_in      = word_ff;
      wr           = '0;
      wr.addr      = pos_ff[5:2];
      wr.lane      = pos_ff[1:0];
      cmd          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               pad_first_in = 1'b1;
               len_phase_in = 1'b0;
               word_in      = '0;
               if (req.has_byte) begin
                  wr.we    = 1'b1;
                  wr.data  = req.data_byte;
                  pos_in   = pos_next;
                  count_in = count_ff + 64'd1;
               end
               if (req.has_byte && pos_ff == POS_LAST) begin
                  state_in = ST_LOAD;
                  ret_in   = req.last_byte ? ST_PAD : ST_IDLE;
               end else if (req.last_byte) begin
                  state_in = ST_PAD;
               end
            end
         end

         ST_PAD: begin
            wr.we = 1'b1;
            priority if (pad_first_ff) begin
               wr.data = PAD_BYTE;
            end else if (len_phase_ff) begin
               wr.data = bit_len[{pos_ff[2:0], 3'b000} +: 8];
            end else begin
               wr.data = '0;
            end
            pos_in       = pos_next;
            pad_first_in = 1'b0;
            if (pos_next == POS_LENGTH) begin
               len_phase_in = 1'b1;
            end
            if (pos_ff == POS_LAST) begin
               state_in = ST_LOAD;
               ret_in   = len_phase_ff ? ST_OUT : ST_PAD;
            end
         end

         ST_LOAD: begin
            cmd.load = 1'b1;
            round_in = '0;
            state_in = ST_ROUND;
         end

         ST_ROUND: begin
            cmd.step = 1'b1;
            round_in = round_ff + 6'd1;
            if (round_ff == ROUND_LAST) begin
               state_in = ST_ADD;
            end
         end

         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = ret_ff;
         end

         ST_OUT: begin
            if (rsp.ready) begin
               word_in = word_ff + 2'd1;
               if (word_ff == WORD_LAST) begin
                  cmd.rearm = 1'b1;
                  count_in  = '0;
                  pos_in    = '0;
                  state_in  = ST_IDLE;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         pos_ff       <= '0;
         count_ff     <= '0;
         round_ff     <= '0;
         pad_first_ff <= 1'b0;
         len_phase_ff <= 1'b0;
         word_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         round_ff     <= round_in;
         pad_first_ff <= pad_first_in;
         len_phase_ff <= len_phase_in;
         word_ff      <= word_in;
      end
   end

endmodule

/* rtl/core/md5_checker.sv */
`include "md5_stream_hasher_core_defines.svh"

module md5_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_digest_word,
   input logic [1:0]  rsp_word_index,
   input logic        rsp_last_word
);

   // no byte is taken while digest words are out
   `MD5_ASSERT_NOW(a_no_req_during_rsp, rsp_valid, !req_ready, "byte taken during digest output")

   // a stalled word holds
   `MD5_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_digest_word) && $stable(rsp_word_index), "stalled digest word changed")

   // last flag only on the fourth word
   `MD5_ASSERT_NOW(a_last_flag, rsp_valid, rsp_last_word == (rsp_word_index == 2'd3), "last_word does not match word_index")

   // words follow in order without gaps
   `MD5_ASSERT_NEXT(a_word_order, rsp_valid && rsp_ready && !rsp_last_word, rsp_valid && (rsp_word_index == $past(rsp_word_index) + 2'd1), "digest words out of order")

   // end of message starts padding, not another byte
   `MD5_ASSERT_NEXT(a_last_stops_req, req_valid && req_ready && req_last_byte, !req_ready && !rsp_valid, "block ready right after end of message")

endmodule

bind md5_stream_hasher_core md5_checker u_md5_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .req_last_byte   (req.last_byte),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_digest_word (rsp.digest_word),
   .rsp_word_index  (rsp.word_index),
   .rsp_last_word   (rsp.last_word)
);

/* tb/tb.sv */
module tb;
   import md5_pkg::*;

   localparam int RESET_CYCLES = 11;
   localparam int BODY_ITEMS   = 240;
   localparam int MIN_MESSAGES = 12;
   localparam int LONG_HOLD_AT = 8;
   localparam int LONG_HOLD    = 600;
   localparam int SETTLE_WAIT  = 300;
   localparam int QUIET_LIMIT  = 5000;
   localparam int REPORT_LIMIT = 10;

   // rotate amounts by quarter and round within a group of four, 5 bits each, entry 0 at lsb
   localparam logic [79:0] ROT_TABLE = {
      5'd21, 5'd15, 5'd10, 5'd6,  5'd23, 5'd16, 5'd11, 5'd4,
      5'd20, 5'd14, 5'd9,  5'd5,  5'd22, 5'd17, 5'd12, 5'd7
   };

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last_byte;
      logic [2:0] gap;
      logic       drain_first;
   } req_item_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [1:0]  word_index;
      logic        last_word;
   } digest_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   md5_req_if req_bus ();
   md5_rsp_if rsp_bus ();

   md5_stream_hasher_core i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   // digest model state
   logic [31:0] sine_k [64];
   logic [31:0] blk_words [16];
   logic [31:0] chain [4];
   logic [63:0] msg_bytes;
   logic [5:0]  blk_pos;

   req_item_type    pending_items [$];
   digest_item_type digest_queue [$];
   req_item_type    next_item;
   req_item_type    offered;
   digest_item_type want_word;
   digest_item_type seen_word;

   int errors = 0;
   int items_taken = 0;
   int words_taken = 0;
   int total_items = 0;
   int wait_left = 0;
   int stall_left = 0;
   int quiet_cycles = 0;
   bit have_next = 1'b0;
   bit burst_mode = 1'b0;
   bit drain_next = 1'b0;
   bit rsp_calm = 1'b0;

   always #1 clock = ~clock;

   // 64 rounds over the current block, added into the chaining value
   function automatic void compress_block();
      logic [31:0] a, b, c, d, f, t;
      int g, s;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int r = 0; r < 64; r++) begin
         case (r / 16)
            0: begin
               f = d ^ (b & (c ^ d));
               g = r;
            end
            1: begin
               f = c ^ (d & (b ^ c));
               g = (5 * r + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               g = (3 * r + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               g = (7 * r) % 16;
            end
         endcase
         s = int'(ROT_TABLE[((r / 16) * 4 + r % 4) * 5 +: 5]);
         t = a + f + sine_k[r] + blk_words[g];
         a = d;
         d = c;
         c = b;
         b = b + ((t << s) | (t >> (32 - s)));
      end
      chain[0] = chain[0] + a;
      chain[1] = chain[1] + b;
      chain[2] = chain[2] + c;
      chain[3] = chain[3] + d;
   endfunction

   // little-endian byte into the block, hash once it is full
   function automatic void put_byte(input logic [7:0] v);
      blk_words[blk_pos[5:2]][8 * blk_pos[1:0] +: 8] = v;
      if (blk_pos == POS_LAST) begin
         compress_block();
      end
      blk_pos = blk_pos + 6'd1;
   endfunction

   function automatic void restart_chain();
      chain[0] = IV_A;
      chain[1] = IV_B;
      chain[2] = IV_C;
      chain[3] = IV_D;
      msg_bytes = '0;
   endfunction

   // one accepted item: absorb its byte, on end of message pad and queue the digest
   function automatic void absorb_item(input req_item_type it);
      logic [63:0] bit_len;
      if (it.has_byte) begin
         put_byte(it.data_byte);
         msg_bytes = msg_bytes + 64'd1;
      end
      if (it.last_byte) begin
         bit_len = msg_bytes << 3;
         put_byte(PAD_BYTE);
         while (blk_pos != POS_LENGTH) put_byte(8'h00);
         for (int i = 0; i < 8; i++) put_byte(bit_len[8 * i +: 8]);
         for (int i = 0; i < 4; i++) begin
            digest_queue.push_back(digest_item_type'{chain[i], 2'(i), 2'(i) == WORD_LAST});
         end
         restart_chain();
      end
   endfunction

   function automatic void add_item(input logic [7:0] d, input logic has, input logic fin);
      req_item_type it;
      it.data_byte = d;
      it.has_byte = has;
      it.last_byte = fin;
      it.gap = burst_mode ? 3'd0 : 3'($urandom_range(0, 7));
      it.drain_first = drain_next;
      drain_next = 1'b0;
      pending_items.push_back(it);
   endfunction

   function automatic void log_mismatch(input string what);
      if (errors < REPORT_LIMIT) begin
         $display("mismatch: %s", what);
      end
      errors++;
   endfunction

   // stimulus, model setup and end of run
   initial begin
      real sv;
      int len, body, msgs;
      bit fold;

      // round constants from the sine, block buffer cleared
      for (int i = 0; i < 64; i++) begin
         sv = $sin(i + 1);
         if (sv < 0.0) sv = -sv;
         sine_k[i] = 32'(longint'($floor(sv * 4294967296.0)));
      end
      for (int i = 0; i < 16; i++) blk_words[i] = '0;
      blk_pos = '0;
      restart_chain();

      // directed: empty message first
      add_item(8'h00, 1'b0, 1'b1);
      // ignored item, then three bytes ending on a byte
      add_item(8'hFF, 1'b0, 1'b0);
      add_item(8'h61, 1'b1, 1'b0);
      add_item(8'h62, 1'b1, 1'b0);
      add_item(8'h63, 1'b1, 1'b1);
      // extreme bytes, end flagged on an item without a byte
      add_item(8'h00, 1'b1, 1'b0);
      add_item(8'hFF, 1'b1, 1'b0);
      add_item(8'hA5, 1'b0, 1'b1);
      // one byte message, then an ignored item and an empty message, back to back
      burst_mode = 1'b1;
      add_item(8'hFF, 1'b1, 1'b1);
      add_item(8'h55, 1'b0, 1'b0);
      add_item(8'hAA, 1'b0, 1'b1);

      // random messages, lengths weighted toward the padding boundaries
      body = 0;
      msgs = 0;
      drain_next = 1'b1;
      while (body < BODY_ITEMS || msgs < MIN_MESSAGES) begin
         if (msgs == 8) drain_next = 1'b1;
         burst_mode = ($urandom_range(0, 2) == 0);
         fold = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 9))
            0, 1: begin
               case ($urandom_range(0, 3))
                  0: len = 55;
                  1: len = 56;
                  2: len = 63;
                  default: len = 64;
               endcase
            end
            2: len = $urandom_range(13, 70);
            default: len = $urandom_range(0, 12);
         endcase
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 11) == 0) begin
               add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            add_item(8'($urandom_range(0, 255)), 1'b1, fold && (k == len - 1));
            body++;
         end
         if (len == 0 || !fold) begin
            add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            body++;
         end
         msgs++;
      end
      total_items = pending_items.size();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (items_taken < total_items) @(negedge clock);
      while (digest_queue.size() != 0) @(negedge clock);
      repeat (SETTLE_WAIT) @(negedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // driver: pause per item, hold a marked item until all digests are back
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         have_next = 1'b0;
         wait_left = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            absorb_item(offered);
            items_taken++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (!have_next && pending_items.size() != 0 &&
                !(pending_items[0].drain_first && digest_queue.size() != 0)) begin
               next_item = pending_items.pop_front();
               wait_left = int'(next_item.gap);
               have_next = 1'b1;
            end
            if (have_next && wait_left == 0) begin
               offered = next_item;
               have_next = 1'b0;
               req_bus.valid <= 1'b1;
               req_bus.data_byte <= next_item.data_byte;
               req_bus.has_byte <= next_item.has_byte;
               req_bus.last_byte <= next_item.last_byte;
            end else begin
               if (have_next) wait_left--;
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each digest word, random stalls and one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_word.digest_word = rsp_bus.digest_word;
            seen_word.word_index = rsp_bus.word_index;
            seen_word.last_word = rsp_bus.last_word;
            if (digest_queue.size() == 0) begin
               log_mismatch($sformatf("unexpected word %h index %0d last %0b",
                  seen_word.digest_word, seen_word.word_index, seen_word.last_word));
            end else begin
               want_word = digest_queue.pop_front();
               if (seen_word.digest_word !== want_word.digest_word ||
                   seen_word.word_index !== want_word.word_index ||
                   seen_word.last_word !== want_word.last_word) begin
                  log_mismatch($sformatf("expected %h/%0d/%0b got %h/%0d/%0b",
                     want_word.digest_word, want_word.word_index, want_word.last_word,
                     seen_word.digest_word, seen_word.word_index, seen_word.last_word));
               end
            end
            words_taken++;
            if (words_taken % 16 == 0) rsp_calm = ($urandom_range(0, 1) == 0);
            if (words_taken == LONG_HOLD_AT) begin
               stall_left = LONG_HOLD;
            end else begin
               stall_left = rsp_calm ? 0 : $urandom_range(0, 7);
            end
         end else if (!rsp_bus.ready && stall_left > 0) begin
            stall_left--;
         end
         rsp_bus.ready <= (stall_left == 0);
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
